[hdl/srx_pkg.sv]
// ----------------------------------------------------------------------------
// srx_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package srx_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 2'd1;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'd85;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd255;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CMD     = 3'd1,
      PH_LEN     = 3'd2,
      PH_RSVD    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DRAIN   = 3'd5
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_DROP  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] frame_length;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] byte_index;
      logic              last_of_frame;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] max_payload;
   } csr_type;

endpackage

`default_nettype wire

[hdl/srx_csr.sv]
// ----------------------------------------------------------------------------
// srx_csr
// Configuration registers: start byte and largest accepted payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module srx_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [srx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [srx_pkg::BYTE_W-1:0]      csr_data,
   output srx_pkg::csr_type                     cfg
);
   import srx_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] start_byte_in;
   logic [BYTE_W-1:0] max_payload_ff;
   logic [BYTE_W-1:0] max_payload_in;

   assign csr_ready = 1'b1;

   // Writes to an index outside the register list are dropped.
   always_comb begin
      start_byte_in  = start_byte_ff;
      max_payload_in = max_payload_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_BYTE:  start_byte_in  = csr_data;
            CSR_MAX_PAYLOAD: max_payload_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         start_byte_ff  <= start_byte_in;
         max_payload_ff <= max_payload_in;
      end
   end

   assign cfg.start_byte  = start_byte_ff;
   assign cfg.max_payload = max_payload_ff;

endmodule

`default_nettype wire

[hdl/srx_fsm.sv]
// ----------------------------------------------------------------------------
// srx_fsm
// Frame state machine: header capture, payload counting and result build.
// ----------------------------------------------------------------------------
`default_nettype none

module srx_fsm (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic [srx_pkg::BYTE_W-1:0] rx_byte,
   input  wire srx_pkg::csr_type           cfg,
   output logic                           res_valid,
   output srx_pkg::result_type            res
);
   import srx_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [BYTE_W-1:0] command_ff;
   logic [BYTE_W-1:0] command_in;
   logic [BYTE_W-1:0] length_ff;
   logic [BYTE_W-1:0] length_in;
   logic [BYTE_W-1:0] seen_ff;
   logic [BYTE_W-1:0] seen_in;
   logic [BYTE_W:0]   seen_next;
   logic              last_byte;

   // One extra bit so the count plus one never wraps in the compare.
   assign seen_next = {1'b0, seen_ff} + {{BYTE_W{1'b0}}, 1'b1};
   assign last_byte = seen_next >= {1'b0, length_ff};

   // Next state and held header values.
   always_comb begin
      phase_in   = phase_ff;
      command_in = command_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      if (take) begin
         case (phase_ff)
            PH_CMD: begin
               command_in = rx_byte;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               length_in = rx_byte;
               phase_in  = PH_RSVD;
            end
            PH_RSVD: begin
               seen_in = '0;
               if (length_ff == '0) begin
                  phase_in = PH_HUNT;
               end else if (length_ff > cfg.max_payload) begin
                  phase_in = PH_DRAIN;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD, PH_DRAIN: begin
               seen_in = seen_next[BYTE_W-1:0];
               if (last_byte) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = (rx_byte == cfg.start_byte) ? PH_CMD : PH_HUNT;
            end
         endcase
      end
   end

   // Result for the byte being taken this cycle.
   always_comb begin
      res_valid         = 1'b0;
      res.kind          = KIND_DATA;
      res.command       = command_ff;
      res.frame_length  = length_ff;
      res.data_byte     = '0;
      res.byte_index    = '0;
      res.last_of_frame = 1'b1;
      case (phase_ff)
         PH_RSVD: begin
            res_valid = (length_ff == '0);
            res.kind  = KIND_EMPTY;
         end
         PH_PAYLOAD: begin
            res_valid         = 1'b1;
            res.data_byte     = rx_byte;
            res.byte_index    = seen_ff;
            res.last_of_frame = last_byte;
         end
         PH_DRAIN: begin
            res_valid = last_byte;
            res.kind  = KIND_DROP;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         command_ff <= '0;
         length_ff  <= '0;
         seen_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

`default_nettype wire

[hdl/srx_out.sv]
// ----------------------------------------------------------------------------
// srx_out
// Result register with valid/stall handshake toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module srx_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire srx_pkg::result_type  res,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output srx_pkg::result_type       rsp
);
   import srx_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The register can take a new result when empty or when it drains now.
   assign busy     = valid_ff & rsp_stall;
   assign valid_in = load | busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire

[hdl/serial_frame_receiver.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Start-byte, length-prefixed frame deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Bytes enter on the req_ channel (req_valid, req_stall, req_rx_byte); a byte
// is taken at a clock edge with req_valid high and req_stall low. Bytes are
// skipped until the start byte; then command and length are held and a
// reserved byte follows. Each accepted payload byte gives one rsp_ transfer;
// a zero length frame gives one empty-frame result on the reserved byte, and a
// frame longer than max_payload gives one drop result on its last byte.
// A result shows on rsp_valid the cycle after its byte is taken. Throughput is
// one byte per cycle when no result is held by rsp_stall, set by the single
// result register; the state machine updates in the cycle the byte is taken.
// While rsp_stall holds a waiting result, req_stall rises and no byte is
// taken; the result and its fields hold until the transfer completes.
// The csr_ channel writes start_byte (index 0) and max_payload (index 1);
// csr_ready is always high and other indexes are ignored.
// Reset returns the block to hunting, clears the output valid flag and sets
// start_byte to 85 and max_payload to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [srx_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [srx_pkg::KIND_W-1:0]           rsp_result_kind,
   output logic [srx_pkg::BYTE_W-1:0]           rsp_command,
   output logic [srx_pkg::BYTE_W-1:0]           rsp_frame_length,
   output logic [srx_pkg::BYTE_W-1:0]           rsp_data_byte,
   output logic [srx_pkg::BYTE_W-1:0]           rsp_byte_index,
   output logic                                 rsp_last_of_frame,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [srx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [srx_pkg::BYTE_W-1:0]      csr_data
);
   import srx_pkg::*;

   csr_type    cfg;
   result_type res;
   result_type rsp;
   logic       res_valid;
   logic       take;
   logic       busy;

   assign req_stall = busy;
   assign take      = req_valid & ~busy;

   srx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   srx_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   srx_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take & res_valid),
      .res       (res),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_result_kind   = rsp.kind;
   assign rsp_command       = rsp.command;
   assign rsp_frame_length  = rsp.frame_length;
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_last_of_frame = rsp.last_of_frame;

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the serial frame receiver.
// ----------------------------------------------------------------------------
// A short table of directed bytes and register writes comes first. Frames of
// random content then follow under several register settings and idle
// patterns. Every byte taken by the block goes through a deframing predictor
// kept in the bench, and each rsp_ transfer is compared field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srx_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_BYTES   = 165;
   localparam int HOLD_CYCLES   = 60;

   // Indexes that map to no register; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_3 = 2'd3;

   localparam result_type NO_RESULT = '{KIND_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             what;
      logic [CSR_INDEX_W-1:0]   index;
      logic [BYTE_W-1:0]        value;
      logic                     pinned;
      result_type               want;
   } directed_row_type;

   typedef struct {
      bit         pinned;
      result_type want;
   } pinned_entry_type;

   localparam int DIRECTED_LEN = 30;
   localparam directed_row_type DIRECTED [DIRECTED_LEN] = '{
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'hFF, 1'b0, NO_RESULT},
      // Zero-length frame closes on its reserved byte.
      '{ROW_BYTE, 2'd0,            8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'hAA, 1'b1,
        '{KIND_EMPTY, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1}},
      // The start byte inside a frame is ordinary header and payload data.
      '{ROW_BYTE, 2'd0,            8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h02, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h55, 1'b1,
        '{KIND_DATA, 8'h00, 8'h02, 8'h55, 8'h00, 1'b0}},
      '{ROW_BYTE, 2'd0,            8'hFF, 1'b1,
        '{KIND_DATA, 8'h00, 8'h02, 8'hFF, 8'h01, 1'b1}},
      '{ROW_CSR,  CSR_MAX_PAYLOAD, 8'h01, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_START_BYTE,  8'h00, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_UNMAPPED_2,  8'hFF, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_UNMAPPED_3,  8'h00, 1'b0, NO_RESULT},
      // Oversized frame; the limit is raised mid-frame and must not apply.
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h5A, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h03, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_MAX_PAYLOAD, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_START_BYTE,  8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h02, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h03, 1'b1,
        '{KIND_DROP, 8'h5A, 8'h03, 8'h00, 8'h00, 1'b1}},
      '{ROW_BYTE, 2'd0,            8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h81, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 2'd0,            8'hFF, 1'b1,
        '{KIND_DATA, 8'h81, 8'h01, 8'hFF, 8'h00, 1'b1}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_W-1:0]      rsp_result_kind;
   logic [BYTE_W-1:0]      rsp_command;
   logic [BYTE_W-1:0]      rsp_frame_length;
   logic [BYTE_W-1:0]      rsp_data_byte;
   logic [BYTE_W-1:0]      rsp_byte_index;
   logic                   rsp_last_of_frame;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_data = '0;

   serial_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_command       (rsp_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Deframer state mirrored by the bench.
   phase_type         frame_phase;
   logic [BYTE_W-1:0] held_cmd;
   logic [BYTE_W-1:0] held_len;
   logic [BYTE_W-1:0] payload_count;
   logic [BYTE_W-1:0] start_value;
   logic [BYTE_W-1:0] payload_limit;

   result_type       expected_results [$];
   pinned_entry_type pinned_results [$];

   int fail_count = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 30;
   int recv_stall_pct = 83;
   int hold_left = 0;

   // Values chosen for the frames of the current phase.
   logic [BYTE_W-1:0] frame_start;
   logic [BYTE_W-1:0] frame_cap;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   function automatic bit deframe_byte(input logic [BYTE_W-1:0] rx, output result_type r);
      bit produced;
      bit last;
      produced = 1'b0;
      r = NO_RESULT;
      case (frame_phase)
         PH_CMD: begin
            held_cmd = rx;
            frame_phase = PH_LEN;
         end
         PH_LEN: begin
            held_len = rx;
            frame_phase = PH_RSVD;
         end
         PH_RSVD: begin
            payload_count = '0;
            if (held_len == '0) begin
               frame_phase = PH_HUNT;
               r = '{KIND_EMPTY, held_cmd, held_len, 8'h00, 8'h00, 1'b1};
               produced = 1'b1;
            end else begin
               frame_phase = (held_len > payload_limit) ? PH_DRAIN : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            last = (int'(payload_count) + 1) >= int'(held_len);
            r = '{KIND_DATA, held_cmd, held_len, rx, payload_count, last};
            produced = 1'b1;
            payload_count = payload_count + 8'd1;
            if (last) begin
               frame_phase = PH_HUNT;
            end
         end
         PH_DRAIN: begin
            last = (int'(payload_count) + 1) >= int'(held_len);
            payload_count = payload_count + 8'd1;
            if (last) begin
               frame_phase = PH_HUNT;
               r = '{KIND_DROP, held_cmd, held_len, 8'h00, 8'h00, 1'b1};
               produced = 1'b1;
            end
         end
         default: begin
            frame_phase = (rx == start_value) ? PH_CMD : PH_HUNT;
         end
      endcase
      return produced;
   endfunction

   task automatic check_result(input result_type want, input result_type got);
      if (got.kind !== want.kind) begin
         $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
         fail_count++;
      end
      if (got.command !== want.command) begin
         $error("command: expected %0h, got %0h", want.command, got.command);
         fail_count++;
      end
      if (got.frame_length !== want.frame_length) begin
         $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
         fail_count++;
      end
      if (got.data_byte !== want.data_byte) begin
         $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
         fail_count++;
      end
      if (got.byte_index !== want.byte_index) begin
         $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
         fail_count++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
         $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                got.last_of_frame);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type       predicted;
      result_type       got;
      pinned_entry_type pin;
      bit               produced;
      if (reset) begin
         frame_phase   = PH_HUNT;
         held_cmd      = '0;
         held_len      = '0;
         payload_count = '0;
         start_value   = START_BYTE_RESET;
         payload_limit = MAX_PAYLOAD_RESET;
      end else begin
         if (csr_valid && csr_ready === 1'b1) begin
            if (csr_index == CSR_START_BYTE) begin
               start_value = csr_data;
            end else if (csr_index == CSR_MAX_PAYLOAD) begin
               payload_limit = csr_data;
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            produced = deframe_byte(req_rx_byte, predicted);
            pin.pinned = 1'b0;
            if (pinned_results.size() != 0) begin
               pin = pinned_results.pop_front();
            end
            // A hand-written expectation takes the place of the predicted one.
            if (pin.pinned) begin
               expected_results.push_back(pin.want);
            end else if (produced) begin
               expected_results.push_back(predicted);
            end
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.kind          = kind_type'(rsp_result_kind);
            got.command       = rsp_command;
            got.frame_length  = rsp_frame_length;
            got.data_byte     = rsp_data_byte;
            got.byte_index    = rsp_byte_index;
            got.last_of_frame = rsp_last_of_frame;
            if (expected_results.size() == 0) begin
               $error("result transfer with no result expected: kind %0d", got.kind);
               fail_count++;
            end else begin
               check_result(expected_results.pop_front(), got);
            end
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value, input bit pinned,
                            input result_type want);
      pinned_entry_type entry;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      entry.pinned = pinned;
      entry.want   = want;
      pinned_results.push_back(entry);
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [BYTE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   // Waits until every expected result has been transferred and the block has
   // had time to finish any byte that gives no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_frame();
      int                noise_len;
      int                frame_len;
      int                total;
      int                pick;
      logic [BYTE_W-1:0] value;
      noise_len = $urandom_range(2, 0);
      repeat (noise_len) send_byte(BYTE_W'($urandom_range(255, 0)), 1'b0, NO_RESULT);
      pick = $urandom_range(99, 0);
      if (pick < 2) begin
         frame_len = $urandom_range(255, 200);
      end else if (pick < 20) begin
         // Lengths around the limit, or medium ones when the limit is high.
         if (frame_cap > 8'd40) begin
            frame_len = $urandom_range(40, 11);
         end else begin
            frame_len = int'(frame_cap) + int'($urandom_range(2, 0)) - 1;
            if (frame_len < 0) begin
               frame_len = 0;
            end
         end
      end else begin
         frame_len = $urandom_range(10, 0);
      end
      total = frame_len + 4;
      if ($urandom_range(99, 0) < 8) begin
         total = $urandom_range(total - 1, 1);
      end
      for (int k = 0; k < total; k++) begin
         if (k == 0) begin
            value = frame_start;
         end else if (k == 2) begin
            value = frame_len[BYTE_W-1:0];
         end else begin
            value = BYTE_W'($urandom_range(255, 0));
         end
         send_byte(value, 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      bit csr_open;
      int target;
      csr_open = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++) begin
         if (DIRECTED[i].what == ROW_CSR) begin
            if (!csr_open) begin
               wait_idle();
            end
            write_csr(DIRECTED[i].index, DIRECTED[i].value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_byte(DIRECTED[i].value, DIRECTED[i].pinned, DIRECTED[i].want);
         end
      end

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         case (p / 2)
            0: begin
               send_idle_pct  = 30;
               recv_stall_pct = 83;
            end
            1: begin
               send_idle_pct  = 83;
               recv_stall_pct = 30;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         case (p)
            0: begin
               frame_start = 8'h00;
               frame_cap   = 8'h00;
            end
            1: begin
               frame_start = BYTE_W'($urandom_range(255, 0));
               frame_cap   = BYTE_W'($urandom_range(12, 1));
            end
            2: begin
               frame_start = 8'hFF;
               frame_cap   = 8'hFF;
            end
            3: begin
               frame_start = BYTE_W'($urandom_range(255, 0));
               frame_cap   = BYTE_W'($urandom_range(40, 0));
            end
            4: begin
               frame_start = BYTE_W'($urandom_range(255, 0));
               frame_cap   = 8'hFF;
            end
            default: begin
               frame_start = BYTE_W'($urandom_range(255, 0));
               frame_cap   = BYTE_W'($urandom_range(8, 1));
            end
         endcase
         write_csr(CSR_START_BYTE, frame_start);
         write_csr(CSR_MAX_PAYLOAD, frame_cap);
         write_csr(($urandom_range(1, 0) != 0) ? CSR_UNMAPPED_2 : CSR_UNMAPPED_3,
                   BYTE_W'($urandom_range(255, 0)));
         csr_valid <= 1'b0;
         // Hold the result side off while bytes keep coming, so the block backs up.
         if (p == 4) begin
            hold_left = HOLD_CYCLES;
         end
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            send_random_frame();
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/srx_pkg.sv
hdl/srx_csr.sv
hdl/srx_fsm.sv
hdl/srx_out.sv
hdl/serial_frame_receiver.sv
dv/tb.sv
